// File: hdl/stsc_pkg.sv
// Shared types, token codes and character tables for the source token scanner.
`default_nettype none

package stsc_pkg;

    localparam int POSITION_BITS = 16;
    localparam int CHAR_W        = 8;
    localparam int KIND_W        = 5;
    localparam int OFFSET_W      = 16;
    localparam int LENGTH_W      = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int KW_COUNT      = 4;
    localparam int KW_MAX_LEN    = 6;

    typedef logic [KIND_W-1:0]        t_kind;
    typedef logic [CHAR_W-1:0]        t_char;
    typedef logic [OFFSET_W-1:0]      t_offset;
    typedef logic [LENGTH_W-1:0]      t_length;
    typedef logic [POSITION_BITS-1:0] t_pos;

    localparam t_kind K_EOF     = KIND_W'(0);
    localparam t_kind K_ID      = KIND_W'(1);
    localparam t_kind K_KW_BASE = KIND_W'(2);
    localparam t_kind K_INT     = KIND_W'(6);
    localparam t_kind K_FLOAT   = KIND_W'(7);
    localparam t_kind K_STRING  = KIND_W'(8);
    localparam t_kind K_CHAR    = KIND_W'(9);
    localparam t_kind K_OP_BASE = KIND_W'(10);
    localparam t_kind K_ERROR   = KIND_W'(25);

    localparam t_length LEN_MAX = '1;

    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_DOT    = 8'h2E;
    localparam t_char CH_DQUOTE = 8'h22;
    localparam t_char CH_SQUOTE = 8'h27;

    // Keyword text, first byte in the top byte: int, float, char, string.
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        48'h696E74000000,
        48'h666C6F617400,
        48'h636861720000,
        48'h737472696E67
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd4, 3'd6};

    typedef struct packed {
        t_kind   kind;
        t_offset start;
        t_length length;
        logic    last;
    } t_token;

    // Up to two tokens from one input item; t1 is only valid with t0.
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token t0;
        t_token t1;
    } t_results;

    function automatic logic is_letter(input t_char c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input t_char c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Byte idx of keyword k; idx must be below the keyword's length.
    function automatic t_char kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [8*KW_MAX_LEN-1:0] row;
        row = KW_TEXT[k];
        return row[8*(KW_MAX_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic is_op(input t_char c);
        logic hit;
        unique case (c)
            8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h3B,
            8'h3A, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h2E: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic t_kind op_kind(input t_char c);
        logic [3:0] idx;
        unique case (c)
            8'h3D:   idx = 4'd0;
            8'h2B:   idx = 4'd1;
            8'h2D:   idx = 4'd2;
            8'h2A:   idx = 4'd3;
            8'h2F:   idx = 4'd4;
            8'h25:   idx = 4'd5;
            8'h5E:   idx = 4'd6;
            8'h3B:   idx = 4'd7;
            8'h3A:   idx = 4'd8;
            8'h28:   idx = 4'd9;
            8'h29:   idx = 4'd10;
            8'h7B:   idx = 4'd11;
            8'h7D:   idx = 4'd12;
            8'h2C:   idx = 4'd13;
            default: idx = 4'd14;
        endcase
        return K_OP_BASE + KIND_W'(idx);
    endfunction

endpackage

`default_nettype wire

// File: hdl/stsc_ifs.sv
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none

interface stsc_char_if;
    logic                  valid;
    logic                  ready;
    stsc_pkg::t_char       char_code;
    logic                  end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface stsc_token_if;
    logic                  valid;
    logic                  ready;
    stsc_pkg::t_kind       token_kind;
    stsc_pkg::t_offset     start_offset;
    stsc_pkg::t_length     token_length;
    logic                  last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/stsc_out_fifo.sv
// Small token queue: takes up to two tokens a cycle, delivers one when the reader is ready.
`default_nettype none

module stsc_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire stsc_pkg::t_results i_res,
    output logic                   o_room,
    stsc_token_if.source           o_token
);

    localparam int PTR_W = $clog2(stsc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(stsc_pkg::QUEUE_DEPTH + 1);

    stsc_pkg::t_token r_mem [stsc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_push;
    logic             pop;
    stsc_pkg::t_token head;

    assign n_push = CNT_W'(i_res.v0) + CNT_W'(i_res.v1);
    assign pop    = o_token.valid && o_token.ready;
    assign o_room = r_count <= CNT_W'(stsc_pkg::QUEUE_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_res.v0) begin
            r_mem[r_wr_ptr] <= i_res.t0;
        end
        if (i_res.v1) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_res.t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + n_push - CNT_W'(pop);
        end
    end

    assign head                 = r_mem[r_rd_ptr];
    assign o_token.valid        = r_count != '0;
    assign o_token.token_kind   = head.kind;
    assign o_token.start_offset = head.start;
    assign o_token.token_length = head.length;
    assign o_token.last_of_run  = head.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(stsc_pkg::QUEUE_DEPTH))
        else $error("token queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.v0 |-> r_count <= CNT_W'(stsc_pkg::QUEUE_DEPTH - 2))
        else $error("tokens pushed without room");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.v1 |-> i_res.v0)
        else $error("second token without first");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 $past(i_rst_n) |->
        r_count == $past(r_count) + $past(n_push) - CNT_W'($past(pop)))
        else $error("token queue count mismatch");

endmodule

`default_nettype wire

// File: hdl/source_token_scanner_core.sv
// Source token scanner top level: per-byte scan state and token emission.
// Tokens of an accepted item are registered into the output queue as it is accepted.
// Throughput: one item per cycle while items give at most one token each and
// tokens are taken as they come; the output port delivers one token a cycle.
// Input is held off while the four-entry token queue has room for fewer than two.
// Reset (synchronous, active low) clears scan state, position and the queue.
`default_nettype none

module source_token_scanner_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stsc_char_if.sink    i_char,
    stsc_token_if.source o_token
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_IDENT, PH_INT, PH_FRAC,
        PH_STRING, PH_CHAR_BODY, PH_CHAR_CLOSE, PH_DEAD
    } t_phase;

    t_phase                r_phase, n_phase;
    stsc_pkg::t_pos        r_pos, n_pos;
    stsc_pkg::t_pos        r_start, n_start;
    stsc_pkg::t_length     r_len, n_len;
    logic [stsc_pkg::KW_COUNT-1:0] r_kw, n_kw;

    logic                  room;
    logic                  accept;
    stsc_pkg::t_char       c;
    stsc_pkg::t_length     len_inc;
    logic [stsc_pkg::KW_COUNT-1:0] kw_match;
    logic [stsc_pkg::KW_COUNT-1:0] kw_first;
    stsc_pkg::t_kind       id_kind;
    logic                  e0_v, e1_v, run_scan;
    stsc_pkg::t_token      e0, e1;
    stsc_pkg::t_results    res;

    function automatic stsc_pkg::t_offset to_offset(input stsc_pkg::t_pos p);
        logic [31:0] w;
        w = 32'(p);
        return w[stsc_pkg::OFFSET_W-1:0];
    endfunction

    function automatic stsc_pkg::t_token mk_tok(input stsc_pkg::t_kind k,
                                                input stsc_pkg::t_pos s,
                                                input stsc_pkg::t_length l);
        stsc_pkg::t_token t;
        t.kind   = k;
        t.start  = to_offset(s);
        t.length = l;
        t.last   = 1'b0;
        return t;
    endfunction

    assign accept       = i_char.valid && i_char.ready;
    assign i_char.ready = room;
    assign c            = i_char.char_code;
    assign len_inc      = (r_len == stsc_pkg::LEN_MAX) ? r_len
                                                       : r_len + stsc_pkg::LENGTH_W'(1);

    // Keyword candidate filtering at byte index r_len, and identifier kind.
    always_comb begin
        for (int k = 0; k < stsc_pkg::KW_COUNT; k++) begin
            kw_match[k] = (r_len < stsc_pkg::LENGTH_W'(stsc_pkg::KW_LEN[k])) &&
                          (stsc_pkg::kw_char(2'(k), r_len[2:0]) == c);
            kw_first[k] = stsc_pkg::kw_char(2'(k), 3'd0) == c;
        end
        id_kind = stsc_pkg::K_ID;
        for (int k = stsc_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (r_kw[k] && r_len == stsc_pkg::LENGTH_W'(stsc_pkg::KW_LEN[k])) begin
                id_kind = stsc_pkg::K_KW_BASE + stsc_pkg::KIND_W'(k);
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_kw     = r_kw;
        e0_v     = 1'b0;
        e1_v     = 1'b0;
        e0       = mk_tok(stsc_pkg::K_EOF, r_pos, '0);
        e1       = e0;
        run_scan = 1'b0;

        if (i_char.end_of_text) begin
            // Flush the pending token, then end-of-file; back to reset state.
            unique case (r_phase)
                PH_IDENT: begin
                    e0_v = 1'b1;
                    e0   = mk_tok(id_kind, r_start, r_len);
                end
                PH_INT: begin
                    e0_v = 1'b1;
                    e0   = mk_tok(stsc_pkg::K_INT, r_start, r_len);
                end
                PH_FRAC: begin
                    e0_v = 1'b1;
                    e0   = mk_tok(stsc_pkg::K_FLOAT, r_start, r_len);
                end
                PH_STRING, PH_CHAR_BODY, PH_CHAR_CLOSE: begin
                    e0_v = 1'b1;
                    e0   = mk_tok(stsc_pkg::K_ERROR, r_start, r_len);
                end
                default: ;
            endcase
            e1_v    = 1'b1;
            e1      = mk_tok(stsc_pkg::K_EOF, r_pos, '0);
            n_phase = PH_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
            n_kw    = '1;
        end else begin
            n_pos = r_pos + stsc_pkg::POSITION_BITS'(1);
            unique case (r_phase)
                PH_IDLE: run_scan = 1'b1;
                PH_IDENT: begin
                    if (stsc_pkg::is_letter(c) || stsc_pkg::is_digit(c)) begin
                        n_kw  = r_kw & kw_match;
                        n_len = len_inc;
                    end else begin
                        e0_v     = 1'b1;
                        e0       = mk_tok(id_kind, r_start, r_len);
                        n_phase  = PH_IDLE;
                        run_scan = 1'b1;
                    end
                end
                PH_INT: begin
                    if (stsc_pkg::is_digit(c)) begin
                        n_len = len_inc;
                    end else if (c == stsc_pkg::CH_DOT) begin
                        n_len   = len_inc;
                        n_phase = PH_FRAC;
                    end else begin
                        e0_v     = 1'b1;
                        e0       = mk_tok(stsc_pkg::K_INT, r_start, r_len);
                        n_phase  = PH_IDLE;
                        run_scan = 1'b1;
                    end
                end
                PH_FRAC: begin
                    if (stsc_pkg::is_digit(c)) begin
                        n_len = len_inc;
                    end else begin
                        e0_v     = 1'b1;
                        e0       = mk_tok(stsc_pkg::K_FLOAT, r_start, r_len);
                        n_phase  = PH_IDLE;
                        run_scan = 1'b1;
                    end
                end
                PH_STRING: begin
                    // Closing quote is consumed; nothing rescanned.
                    if (c == stsc_pkg::CH_DQUOTE) begin
                        e0_v    = 1'b1;
                        e0      = mk_tok(stsc_pkg::K_STRING, r_start, r_len);
                        n_phase = PH_IDLE;
                    end else begin
                        n_len = len_inc;
                    end
                end
                PH_CHAR_BODY: begin
                    n_start = r_pos;
                    n_len   = stsc_pkg::LENGTH_W'(1);
                    n_phase = PH_CHAR_CLOSE;
                end
                PH_CHAR_CLOSE: begin
                    if (c == stsc_pkg::CH_SQUOTE) begin
                        e0_v    = 1'b1;
                        e0      = mk_tok(stsc_pkg::K_CHAR, r_start, r_len);
                        n_phase = PH_IDLE;
                    end else begin
                        e0_v    = 1'b1;
                        e0      = mk_tok(stsc_pkg::K_ERROR, r_start, r_len);
                        n_phase = PH_DEAD;
                    end
                end
                PH_DEAD: ;
            endcase

            if (run_scan) begin
                priority if (stsc_pkg::is_letter(c)) begin
                    n_start = r_pos;
                    n_len   = stsc_pkg::LENGTH_W'(1);
                    n_kw    = kw_first;
                    n_phase = PH_IDENT;
                end else if (stsc_pkg::is_digit(c)) begin
                    n_start = r_pos;
                    n_len   = stsc_pkg::LENGTH_W'(1);
                    n_phase = PH_INT;
                end else if (c == stsc_pkg::CH_DQUOTE) begin
                    n_start = r_pos + stsc_pkg::POSITION_BITS'(1);
                    n_len   = '0;
                    n_phase = PH_STRING;
                end else if (c == stsc_pkg::CH_SQUOTE) begin
                    n_start = r_pos + stsc_pkg::POSITION_BITS'(1);
                    n_len   = '0;
                    n_phase = PH_CHAR_BODY;
                end else if (stsc_pkg::is_op(c)) begin
                    e1_v = 1'b1;
                    e1   = mk_tok(stsc_pkg::op_kind(c), r_pos, stsc_pkg::LENGTH_W'(1));
                end else begin
                    // Space, newline and unknown bytes are skipped.
                end
            end
        end
    end

    // Pack the tokens into the queue's first slots and mark the last one.
    always_comb begin
        res.v0 = accept && (e0_v || e1_v);
        res.v1 = accept && e0_v && e1_v;
        res.t0 = e0_v ? e0 : e1;
        res.t1 = e1;
        res.t0.last = !(e0_v && e1_v);
        res.t1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_kw    <= '1;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_kw    <= n_kw;
        end
    end

    stsc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_token (o_token)
    );

    a_eot_ends_with_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_char.end_of_text) |->
        (res.v0 && (res.v1 ? res.t1.kind : res.t0.kind) == stsc_pkg::K_EOF))
        else $error("end of text without end-of-file token");

    a_eot_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_char.end_of_text) |=> (r_pos == '0 && r_phase == PH_IDLE))
        else $error("scanner not back to start after end of text");

    a_dead_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_DEAD && !i_char.end_of_text) |-> !res.v0)
        else $error("token emitted after error");

endmodule

`default_nettype wire
